// ===== hw/rtl/nf4_group_scaled_dot_engine_unit_defines.svh =====
// Assertion macros used by the NF4 dot engine sequencer.
`ifndef NF4_GROUP_SCALED_DOT_ENGINE_UNIT_DEFINES_SVH
`define NF4_GROUP_SCALED_DOT_ENGINE_UNIT_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define NF4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the same cycle.
`define NF4_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/nf4dot_pkg.sv =====
// Shared types, constants and fp32 arithmetic for the NF4 dot engine.
package nf4dot_pkg;

    localparam int Lanes = 16;
    localparam logic [31:0] QNan = 32'h7FC0_0000;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ADD, ST_FMUL, ST_FADD, ST_EMIT
    } t_state;

    typedef struct packed {
        logic acc_mul;   // latch products act * code
        logic acc_add;   // partial += product
        logic fold_mul;  // latch products scale * partial
        logic fold_add;  // accum += product, clear partial
        logic clear;     // clear partial and accum
        logic load;      // write one lane scale
    } t_lane_ctl;

    function automatic logic [31:0] codebook(input logic [3:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                4'd0:    v = 32'hBF80_0000;
                4'd1:    v = 32'hBF32_39B1;
                4'd2:    v = 32'hBF06_6B30;
                4'd3:    v = 32'hBECA_32A0;
                4'd4:    v = 32'hBE91_A24D;
                4'd5:    v = 32'hBE3D_353F;
                4'd6:    v = 32'hBDBA_7872;
                4'd7:    v = 32'h0000_0000;
                4'd8:    v = 32'h3DA2_FAFF;
                4'd9:    v = 32'h3E24_CAE3;
                4'd10:   v = 32'h3E7C_04DD;
                4'd11:   v = 32'h3EAD_033A;
                4'd12:   v = 32'h3EE1_A4B8;
                4'd13:   v = 32'h3F10_07AB;
                4'd14:   v = 32'h3F39_13B3;
                default: v = 32'h3F80_0000;
            endcase
            return v;
        end
    endfunction

    // Round a 27-bit significand (hidden at bit 26, guard bits 2:0 + sticky) at
    // biased exponent e (may be <=0 for subnormals) into an fp32 pattern.
    function automatic logic [31:0] fp_pack(input logic s, input logic signed [10:0] e,
                                            input logic [26:0] m);
        logic [26:0] mm;
        logic signed [10:0] ee;
        logic [5:0] sh;
        logic st;
        logic [24:0] r;
        logic [31:0] res;
        begin
            mm = m;
            ee = e;
            st = 1'b0;
            if (ee < 11'sd1) begin
                sh = (11'sd1 - ee > 11'sd27) ? 6'd27 : 6'((11'sd1 - ee));
                st = |(mm & ((27'd1 << sh) - 27'd1));
                mm = (mm >> sh) | {26'd0, st};
                ee = 11'sd0;
            end
            r = {1'b0, mm[26:3]};
            if (mm[2] && (mm[1] || mm[0] || mm[3]))
                r = r + 25'd1;
            if (r[24]) begin
                r = r >> 1;
                ee = ee + 11'sd1;
            end else if (ee == 11'sd0 && r[23]) begin
                ee = 11'sd1;
            end
            if (ee >= 11'sd255)
                res = {s, 8'hFF, 23'd0};
            else
                res = {s, ee[7:0], r[22:0]};
            return res;
        end
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        logic [7:0] ea, eb;
        logic [23:0] ma, mb;
        logic [47:0] p;
        logic signed [10:0] e;
        logic [5:0] lz;
        logic [26:0] m;
        logic [31:0] res;
        begin
            s = a[31] ^ b[31];
            ea = a[30:23];
            eb = b[30:23];
            ma = {ea != 8'd0, a[22:0]};
            mb = {eb != 8'd0, b[22:0]};
            lz = 6'd0;
            if ((ea == 8'hFF && a[22:0] != 23'd0) || (eb == 8'hFF && b[22:0] != 23'd0))
                res = QNan;
            else if (ea == 8'hFF || eb == 8'hFF)
                res = ((ea == 8'd0 && ma == 24'd0) || (eb == 8'd0 && mb == 24'd0)) ?
                      QNan : {s, 8'hFF, 23'd0};
            else if (ma == 24'd0 || mb == 24'd0)
                res = {s, 31'd0};
            else begin
                p = ma * mb;
                e = 11'(ea) + 11'(eb) - 11'sd126 + ((ea == 8'd0) ? 11'sd1 : 11'sd0)
                    + ((eb == 8'd0) ? 11'sd1 : 11'sd0);
                // leading one search: highest set bit wins
                for (int i = 0; i < 47; i++)
                    if (p[i])
                        lz = 6'(47 - i);
                if (p[47])
                    lz = 6'd0;
                p = p << lz;
                e = e - 11'(lz);
                m = {p[47:22], |p[21:0]};
                res = fp_pack(s, e, m);
            end
            return res;
        end
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x, y, res;
        logic [7:0] ex, ey;
        logic [8:0] d;
        logic [27:0] mx, my, sm;
        logic st;
        logic signed [10:0] e;
        logic [5:0] lz;
        begin
            lz = 6'd0;
            if ((a[30:23] == 8'hFF && a[22:0] != 23'd0) ||
                (b[30:23] == 8'hFF && b[22:0] != 23'd0))
                res = QNan;
            else if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
                if (a[30:23] == 8'hFF && b[30:23] == 8'hFF && a[31] != b[31])
                    res = QNan;
                else
                    res = (a[30:23] == 8'hFF) ? a : b;
            end else begin
                if (a[30:0] >= b[30:0]) begin x = a; y = b; end
                else begin x = b; y = a; end
                ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
                ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
                mx = {1'b0, x[30:23] != 8'd0, x[22:0], 3'd0};
                my = {1'b0, y[30:23] != 8'd0, y[22:0], 3'd0};
                d = {1'b0, ex} - {1'b0, ey};
                if (d > 9'd27) begin
                    st = |my;
                    my = {27'd0, st};
                end else begin
                    st = |(my & ((28'd1 << d[4:0]) - 28'd1));
                    my = (my >> d[4:0]) | {27'd0, st};
                end
                sm = (x[31] == y[31]) ? mx + my : mx - my;
                if (sm == 28'd0)
                    res = (x[31] == y[31]) ? {x[31], 31'd0} : 32'd0;
                else begin
                    e = 11'(ex) + 11'sd1;
                    for (int i = 0; i < 27; i++)
                        if (sm[i])
                            lz = 6'(27 - i);
                    if (sm[27])
                        lz = 6'd0;
                    if (11'(lz) > e - 11'sd1)
                        lz = 6'(e - 11'sd1);
                    sm = sm << lz;
                    e = e - 11'(lz);
                    res = fp_pack(x[31], e, {sm[27:2], |sm[1:0]});
                    if (e == 11'sd1 && !sm[27])
                        res = fp_pack(x[31], 11'sd0, {sm[27:2], |sm[1:0]} << 1);
                end
            end
            return res;
        end
    endfunction

endpackage

// ===== hw/rtl/nf4dot_lane.sv =====
// One column lane: scale, group partial and output accumulator with fp32 units.
module nf4dot_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nf4dot_pkg::t_lane_ctl i_ctl,
    input  logic [31:0]          i_act,
    input  logic [3:0]           i_idx,
    input  logic [31:0]          i_scale,
    output logic [31:0]          o_accum
);
    logic [31:0] r_scale, r_part, r_acc, r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= '0;
            r_part  <= '0;
            r_acc   <= '0;
            r_prod  <= '0;
        end else begin
            if (i_ctl.load)
                r_scale <= i_scale;
            if (i_ctl.acc_mul)
                r_prod <= nf4dot_pkg::fp_mul(i_act, nf4dot_pkg::codebook(i_idx));
            else if (i_ctl.fold_mul)
                r_prod <= nf4dot_pkg::fp_mul(r_scale, r_part);
            if (i_ctl.acc_add)
                r_part <= nf4dot_pkg::fp_add(r_part, r_prod);
            if (i_ctl.fold_add) begin
                r_acc  <= nf4dot_pkg::fp_add(r_acc, r_prod);
                r_part <= '0;
            end
            if (i_ctl.clear) begin
                r_acc  <= '0;
                r_part <= '0;
            end
        end
    end

    assign o_accum = r_acc;
endmodule

// ===== hw/rtl/nf4dot_ctrl.sv =====
// Sequencer: steps accumulate items through multiply and add, group ends through fold, tile ends through emit.
`include "nf4_group_scaled_dot_engine_unit_defines.svh"
module nf4dot_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_fire,
    input  logic                  i_op,
    input  logic                  i_group_end,
    input  logic                  i_tile_end,
    input  logic                  i_out_fire,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output logic [3:0]            o_emit_lane,
    output logic                  o_emit_last,
    output logic                  o_clear,
    output nf4dot_pkg::t_lane_ctl o_ctl
);
    nf4dot_pkg::t_state r_state, n_state;
    logic r_gend, r_tend;
    logic [3:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nf4dot_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_gend  <= 1'b0;
            r_tend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_in_fire) begin
                r_gend <= i_group_end;
                r_tend <= i_tile_end;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        o_ctl = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        o_clear = 1'b0;
        unique case (r_state)
            nf4dot_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_ctl.load = !i_op;
                    if (i_op)
                        n_state = nf4dot_pkg::ST_MUL;
                    else if (i_group_end)
                        n_state = nf4dot_pkg::ST_FMUL;
                    else if (i_tile_end)
                        n_state = nf4dot_pkg::ST_EMIT;
                end
            end
            nf4dot_pkg::ST_MUL: begin
                o_ctl.acc_mul = 1'b1;
                n_state = nf4dot_pkg::ST_ADD;
            end
            nf4dot_pkg::ST_ADD: begin
                o_ctl.acc_add = 1'b1;
                n_state = r_gend ? nf4dot_pkg::ST_FMUL :
                          r_tend ? nf4dot_pkg::ST_EMIT : nf4dot_pkg::ST_IDLE;
            end
            nf4dot_pkg::ST_FMUL: begin
                o_ctl.fold_mul = 1'b1;
                n_state = nf4dot_pkg::ST_FADD;
            end
            nf4dot_pkg::ST_FADD: begin
                o_ctl.fold_add = 1'b1;
                n_state = r_tend ? nf4dot_pkg::ST_EMIT : nf4dot_pkg::ST_IDLE;
            end
            nf4dot_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_fire) begin
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'(nf4dot_pkg::Lanes - 1)) begin
                        n_cnt = '0;
                        o_ctl.clear = 1'b1;
                        o_clear = 1'b1;
                        n_state = nf4dot_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = nf4dot_pkg::ST_IDLE;
        endcase
    end

    assign o_emit_lane = r_cnt;
    assign o_emit_last = (r_cnt == 4'(nf4dot_pkg::Lanes - 1));

    `NF4_ASSERT_SAME(a_ready_idle, i_clk, i_rst_n, o_in_ready, !o_out_valid, "ready while emitting")
    `NF4_ASSERT_NEXT(a_mul_add, i_clk, i_rst_n, r_state == nf4dot_pkg::ST_MUL, r_state == nf4dot_pkg::ST_ADD, "add missed")
    `NF4_ASSERT_NEXT(a_clear_idle, i_clk, i_rst_n, o_clear, r_state == nf4dot_pkg::ST_IDLE && r_cnt == 4'd0, "emit end")
endmodule

// ===== hw/rtl/nf4_group_scaled_dot_engine_unit.sv =====
// Top level of the NF4 grouped scaled dot engine: lanes, sequencer, result mux.
//  channel | dir | tdata fields (low first)                      | tuser | tlast
//  s_axis  | in  | lane, scale_bits, activation_bits, index_word, | op    | tile_end
//          |     | group_end (133 bits, padded to 136)           |       |
//  m_axis  | out | out_lane, result_bits (36, padded to 40)      | -     | last
// Accumulate item: MUL then ADD states, plus FMUL and FADD for a group fold; a scale load
// is written on acceptance. The lanes' registered fp32 multiply then add set these steps.
// Tile end: 16 result transfers, one per cycle while m_axis_tready is high.
// Reset (i_rst_n, synchronous) clears scales, partials and accumulators.
// Input is not taken while results are pending.
module nf4_group_scaled_dot_engine_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // lane[3:0], scale_bits[35:4], activation_bits[67:36],
    // index_word[131:68], group_end[132]
    input  logic [135:0] s_axis_tdata,
    // op
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_lane[3:0], result_bits[35:4]
    output logic [39:0]  m_axis_tdata,
    output logic         m_axis_tlast
);
    logic in_fire, out_fire, clr;
    logic [3:0] emit_lane;
    logic emit_last;
    nf4dot_pkg::t_lane_ctl ctl;
    logic [31:0] r_act;
    logic [63:0] r_idx;
    logic [31:0] acc [nf4dot_pkg::Lanes];
    logic [31:0] res;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_act <= s_axis_tdata[67:36];
            r_idx <= s_axis_tdata[131:68];
        end
    end

    nf4dot_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_op        (s_axis_tuser),
        .i_group_end (s_axis_tdata[132]),
        .i_tile_end  (s_axis_tlast),
        .i_out_fire  (out_fire),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_emit_lane (emit_lane),
        .o_emit_last (emit_last),
        .o_clear     (clr),
        .o_ctl       (ctl)
    );

    for (genvar c = 0; c < nf4dot_pkg::Lanes; c++) begin : g_lane
        nf4dot_pkg::t_lane_ctl lctl;
        always_comb begin
            lctl = ctl;
            lctl.load = ctl.load && (s_axis_tdata[3:0] == 4'(c));
            lctl.clear = clr;
        end
        nf4dot_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lctl),
            .i_act   (r_act),
            .i_idx   (r_idx[4*c +: 4]),
            .i_scale (s_axis_tdata[35:4]),
            .o_accum (acc[c])
        );
    end

    // merge: pick the lane being sent, canonicalize NaN
    always_comb begin
        res = acc[emit_lane];
        if (res[30:23] == 8'hFF && res[22:0] != 23'd0)
            res = nf4dot_pkg::QNan;
    end

    assign m_axis_tdata = {4'd0, res, emit_lane};
    assign m_axis_tlast = emit_last;
endmodule
